// ----- sv/dtt_pkg.sv -----
// Shared types and codes for the deadline timer table.
// Depends on nothing; the core, controller, datapath and checker import it.
`default_nettype none

package dtt_pkg;

	localparam int DL_W  = 48;
	localparam int PER_W = 32;
	localparam int TAG_W = 16;
	localparam int ID_W  = 32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ADDED   = 2'd0,
		KIND_REMOVED = 2'd1,
		KIND_FIRED   = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	typedef struct packed {
		op_t              operation;
		logic [DL_W-1:0]  deadline;
		logic [PER_W-1:0] period;
		logic [TAG_W-1:0] event_tag;
		logic [ID_W-1:0]  timer_id;
		logic [DL_W-1:0]  now_time;
	} in_item_t;

	typedef struct packed {
		kind_t            kind;
		logic             status;
		logic [ID_W-1:0]  out_id;
		logic [TAG_W-1:0] out_tag;
		logic             next_valid;
		logic [DL_W-1:0]  next_deadline;
		logic [PER_W-1:0] next_period;
		logic             last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_START,
		ST_SCAN,
		ST_EVAL,
		ST_FIRE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  latch;
		logic  add;
		logic  scan_start;
		logic  fire;
		logic  emit;
		kind_t kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic scan_done;
		logic due_found;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/dtt_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transfer.
// Depends on nothing; the payload type is given at instantiation.
`default_nettype none

interface dtt_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/deadline_timer_table_core.sv -----
// Deadline timer table. One operation at a time; a table scan reads one
// slot per cycle from the slot memories.
// Reset clears valid bits, the id counter and all control; slot data is not cleared.
`default_nettype none

module deadline_timer_table_core #(
	parameter int TABLE_DEPTH = 16
) (
	input wire logic    clk,
	input wire logic    arst_n,
	dtt_stream_if.sink  cmd,
	dtt_stream_if.source rsp
);
	import dtt_pkg::*;

	dp_cmd_t   dp_cmd;
	dp_sts_t   dp_sts;
	logic      ctl_ready;
	logic      dp_out_valid;
	out_item_t dp_out;

	dtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (ctl_ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	dtt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (cmd.payload),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.out_valid (dp_out_valid),
		.out_ready (rsp.ready),
		.out_item  (dp_out)
	);

	assign cmd.ready   = ctl_ready;
	assign rsp.valid   = dp_out_valid;
	assign rsp.payload = dp_out;

endmodule

`default_nettype wire

// ----- sv/dtt_ctrl.sv -----
// Sequencer for the timer table: steps each operation through scans,
// firings and result transfers. Depends on dtt_pkg.
`default_nettype none

module dtt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  dtt_pkg::dp_sts_t     sts,
	output dtt_pkg::dp_cmd_t     cmd
);
	import dtt_pkg::*;

	state_t state_q, state_n;
	logic   pend_q, pend_n;

	// state and pending-firing flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			pend_q  <= pend_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		pend_n   = pend_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = KIND_DONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					pend_n    = 1'b0;
					state_n   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.op)
					OP_ADD: begin
						cmd.add = 1'b1;
						state_n = ST_START;
					end
					OP_REMOVE, OP_TICK: state_n = ST_START;
					default: state_n = ST_IDLE;
				endcase
			end
			ST_START: begin
				cmd.scan_start = 1'b1;
				state_n        = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					if (sts.op == OP_TICK && !pend_q) begin
						state_n = ST_EVAL;
					end else begin
						state_n = ST_EMIT;
					end
				end
			end
			ST_EVAL: begin
				if (sts.due_found) begin
					state_n = ST_FIRE;
				end else begin
					state_n = ST_EMIT;
				end
			end
			ST_FIRE: begin
				cmd.fire = 1'b1;
				pend_n   = 1'b1;
				state_n  = ST_START;
			end
			ST_EMIT: begin
				unique case (sts.op)
					OP_ADD:    cmd.kind = KIND_ADDED;
					OP_REMOVE: cmd.kind = KIND_REMOVED;
					default:   cmd.kind = pend_q ? KIND_FIRED : KIND_DONE;
				endcase
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.op == OP_TICK && pend_q) begin
						pend_n  = 1'b0;
						state_n = ST_EVAL;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/dtt_datapath.sv -----
// Timer slot storage, sequential scan with (deadline, id) minimum search,
// firing update and the result register. Depends on dtt_pkg.
`default_nettype none

module dtt_datapath #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  dtt_pkg::in_item_t    in_item,
	input  dtt_pkg::dp_cmd_t     cmd,
	output dtt_pkg::dp_sts_t     sts,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output dtt_pkg::out_item_t   out_item
);
	import dtt_pkg::*;

	localparam int            IW       = $clog2(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	in_item_t item_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] fired_q;
	logic [ID_W-1:0] id_cnt_q;
	logic add_fail_q;

	// slot memories
	logic [DL_W-1:0]  dl_mem  [TABLE_DEPTH];
	logic [PER_W-1:0] per_mem [TABLE_DEPTH];
	logic [TAG_W-1:0] tag_mem [TABLE_DEPTH];
	logic [ID_W-1:0]  id_mem  [TABLE_DEPTH];

	// scan control and read stage
	logic rd_act_q;
	logic [IW-1:0] rd_idx_q;
	logic cmp_v_s1;
	logic [IW-1:0] idx_s1;
	logic [DL_W-1:0] rd_dl_s1;
	logic [PER_W-1:0] rd_per_s1;
	logic [TAG_W-1:0] rd_tag_s1;
	logic [ID_W-1:0] rd_id_s1;
	logic scan_done_q;

	// best overall and best due-and-unfired
	logic ba_v_q;
	logic [DL_W-1:0] ba_dl_q;
	logic [PER_W-1:0] ba_per_q;
	logic [ID_W-1:0] ba_id_q;
	logic bd_v_q;
	logic [IW-1:0] bd_idx_q;
	logic [DL_W-1:0] bd_dl_q;
	logic [PER_W-1:0] bd_per_q;
	logic [TAG_W-1:0] bd_tag_q;
	logic [ID_W-1:0] bd_id_q;

	logic [ID_W-1:0] fire_id_q;
	logic [TAG_W-1:0] fire_tag_q;

	logic out_v_q;
	out_item_t out_q;

	logic free_found;
	logic [IW-1:0] free_idx;
	logic add_ok;
	logic [DL_W:0] resched_sum;
	logic [DL_W-1:0] resched_dl;
	logic e_valid, e_match, e_live, e_due, a_before, d_before;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign add_ok = cmd.add && free_found;

	// saturating reschedule: now + period, clamped to the top of the range
	assign resched_sum = {1'b0, item_q.now_time} + {{(DL_W + 1 - PER_W){1'b0}}, bd_per_q};
	assign resched_dl  = resched_sum[DL_W] ? {DL_W{1'b1}} : resched_sum[DL_W-1:0];

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_item;
		end
	end

	// id counter and add outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_cnt_q   <= '0;
			add_fail_q <= 1'b0;
		end else if (cmd.add) begin
			add_fail_q <= !free_found;
			if (free_found) begin
				id_cnt_q <= id_cnt_q + 1'b1;
			end
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (add_ok) begin
			dl_mem[free_idx]  <= item_q.deadline;
			per_mem[free_idx] <= item_q.period;
			tag_mem[free_idx] <= item_q.event_tag;
			id_mem[free_idx]  <= id_cnt_q + 1'b1;
		end else if (cmd.fire && bd_per_q != '0) begin
			dl_mem[bd_idx_q] <= resched_dl;
		end
	end

	// memory read port
	always_ff @(posedge clk) begin
		if (rd_act_q) begin
			rd_dl_s1  <= dl_mem[rd_idx_q];
			rd_per_s1 <= per_mem[rd_idx_q];
			rd_tag_s1 <= tag_mem[rd_idx_q];
			rd_id_s1  <= id_mem[rd_idx_q];
			idx_s1    <= rd_idx_q;
		end
	end

	// advance the scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q    <= 1'b0;
			rd_idx_q    <= '0;
			cmp_v_s1    <= 1'b0;
			scan_done_q <= 1'b0;
		end else begin
			cmp_v_s1    <= rd_act_q;
			scan_done_q <= cmp_v_s1 && idx_s1 == LAST_IDX;
			if (cmd.scan_start) begin
				rd_act_q <= 1'b1;
				rd_idx_q <= '0;
			end else if (rd_act_q) begin
				if (rd_idx_q == LAST_IDX) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	// classify the entry read in the last cycle
	always_comb begin
		e_valid  = valid_q[idx_s1];
		e_match  = item_q.operation == OP_REMOVE && e_valid && rd_id_s1 == item_q.timer_id;
		e_live   = e_valid && !e_match;
		e_due    = e_live && item_q.operation == OP_TICK && !fired_q[idx_s1]
			&& rd_dl_s1 <= item_q.now_time;
		a_before = !ba_v_q || rd_dl_s1 < ba_dl_q
			|| (rd_dl_s1 == ba_dl_q && rd_id_s1 < ba_id_q);
		d_before = !bd_v_q || rd_dl_s1 < bd_dl_q
			|| (rd_dl_s1 == bd_dl_q && rd_id_s1 < bd_id_q);
	end

	// best-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ba_v_q <= 1'b0;
			bd_v_q <= 1'b0;
		end else if (cmd.scan_start) begin
			ba_v_q <= 1'b0;
			bd_v_q <= 1'b0;
		end else if (cmp_v_s1) begin
			if (e_live && a_before) begin
				ba_v_q <= 1'b1;
			end
			if (e_due && d_before) begin
				bd_v_q <= 1'b1;
			end
		end
	end

	// best-entry payload
	always_ff @(posedge clk) begin
		if (cmp_v_s1 && e_live && a_before) begin
			ba_dl_q  <= rd_dl_s1;
			ba_per_q <= rd_per_s1;
			ba_id_q  <= rd_id_s1;
		end
		if (cmp_v_s1 && e_due && d_before) begin
			bd_idx_q <= idx_s1;
			bd_dl_q  <= rd_dl_s1;
			bd_per_q <= rd_per_s1;
			bd_tag_q <= rd_tag_s1;
			bd_id_q  <= rd_id_s1;
		end
	end

	// slot valid and fired bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fired_q <= '0;
		end else begin
			if (cmd.latch) begin
				fired_q <= '0;
			end
			if (add_ok) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmp_v_s1 && e_match) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.fire) begin
				fired_q[bd_idx_q] <= 1'b1;
				if (bd_per_q == '0) begin
					valid_q[bd_idx_q] <= 1'b0;
				end
			end
		end
	end

	// capture the fired timer for its result
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			fire_id_q  <= bd_id_q;
			fire_tag_q <= bd_tag_q;
		end
	end

	// result register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.kind          <= cmd.kind;
			out_q.status        <= cmd.kind == KIND_ADDED && add_fail_q;
			out_q.out_tag       <= (cmd.kind == KIND_FIRED) ? fire_tag_q : '0;
			out_q.next_valid    <= ba_v_q;
			out_q.next_deadline <= ba_v_q ? ba_dl_q : '0;
			out_q.next_period   <= ba_v_q ? ba_per_q : '0;
			out_q.last          <= cmd.kind != KIND_FIRED;
			case (cmd.kind)
				KIND_ADDED:   out_q.out_id <= add_fail_q ? '0 : id_cnt_q;
				KIND_REMOVED: out_q.out_id <= item_q.timer_id;
				KIND_FIRED:   out_q.out_id <= fire_id_q;
				default:      out_q.out_id <= '0;
			endcase
		end
	end

	assign out_valid     = out_v_q;
	assign out_item      = out_q;
	assign sts.op        = item_q.operation;
	assign sts.scan_done = scan_done_q;
	assign sts.due_found = bd_v_q;
	assign sts.out_free  = !out_v_q || out_ready;

endmodule

`default_nettype wire

// ----- sv/dtt_checker.sv -----
// Port-level checks for the deadline timer table, bound to the top level.
// Depends on dtt_pkg and deadline_timer_table_core.
`default_nettype none

module dtt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cmd_valid,
	input wire logic          cmd_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input dtt_pkg::out_item_t rsp_payload
);
	import dtt_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result changed while stalled");

	// only a firing leaves the operation open
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_payload.last == (rsp_payload.kind != KIND_FIRED)))
		else $error("last flag does not match result kind");

	// empty table reports zero next fields and tags only on firings
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_payload.next_valid || (rsp_payload.next_deadline == '0
			&& rsp_payload.next_period == '0))
			&& (rsp_payload.kind == KIND_FIRED || rsp_payload.out_tag == '0))
		else $error("fixed result fields not zero");

	// no second input transfer right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("input taken while an operation is in progress");

endmodule

bind deadline_timer_table_core dtt_checker u_dtt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

`default_nettype wire
